FILE: rtl/ape_pkg.sv
// Shared types and constants for the averaged perceptron engine.
`timescale 1ns / 1ps

package ape_pkg;

    // Request kinds carried on the input tuser
    localparam logic [1:0] KIND_SCORE = 2'd0;
    localparam logic [1:0] KIND_LABEL = 2'd1;
    localparam logic [1:0] KIND_DELTA = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_FEATURES = 2'd0;
    localparam logic [1:0] CFG_LEARN_RATE   = 2'd1;
    localparam logic [1:0] CFG_LOCK_BIAS    = 2'd2;
    localparam logic [1:0] CFG_MIN_INDEX    = 2'd3;

    localparam int CFG_DATA_W = 17;
    localparam int SCORE_W    = 48;
    localparam int SUM_W      = 48;
    localparam int COUNT_W    = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 152;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_CALC  = 7'b0001000,
        ST_ACC   = 7'b0010000,
        ST_AVG   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;      // run the store clearing sweep
        logic load_item;  // latch an accepted input item
        logic read_item;  // read the weight of the latched item
        logic calc;       // form product, write updated weight
        logic acc;        // fold product into score
        logic avg_start;  // restart the averaging sweep
        logic avg_run;    // advance the averaging sweep
        logic load_out;   // load the result register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_done;
        logic avg_done;
        logic out_free;
        logic last;
        logic is_update;
    } t_status;

endpackage

FILE: rtl/averaged_perceptron_engine_core.sv
// Top level of the sparse averaged perceptron engine.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata, tuser (req_type), tlast
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata (result)
// cfg       in   i_cfg_wr_en                      i_cfg_index, i_cfg_wdata
//
// Each feature item passes through accept, weight read, multiply and weight
// write, and score add; the last item of an example then loads the result,
// waiting while the result register is full. The last item of an update example
// adds a sweep over the active weights, one weight and running sum per cycle.
// After reset a clearing sweep over all MAX_FEATURES addresses zeroes both stores.
// Items keep flowing while a result waits on m_axis; the next result holds
// until the result register frees.

module averaged_perceptron_engine_core
    import ape_pkg::*;
#(
    parameter int MAX_FEATURES = 65536,
    parameter int WEIGHT_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [15:0] feature_index, [31:16] feature_value, [33:32] label, rest zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]            i_s_axis_tuser,
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [47:0] score, [48] prediction_correct, [80:49] correct_count,
    // [112:81] labelled_count, [144:113] update_count, rest zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    t_cmd    w_cmd;
    t_status w_status;

    ape_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ape_datapath #(
        .MAX_FEATURES (MAX_FEATURES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_kind      (i_s_axis_tuser),
        .i_index     (i_s_axis_tdata[15:0]),
        .i_value     (i_s_axis_tdata[31:16]),
        .i_label     (i_s_axis_tdata[33:32]),
        .i_last      (i_s_axis_tlast),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

FILE: rtl/ape_ctrl.sv
// Controller state machine for the averaged perceptron engine.
`timescale 1ns / 1ps

module ape_ctrl
    import ape_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // Decode next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read_item = 1'b1;
                n_state = ST_CALC;
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                if (!i_status.last) begin
                    n_state = ST_IDLE;
                end else if (i_status.is_update) begin
                    o_cmd.avg_start = 1'b1;
                    n_state = ST_AVG;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_AVG: begin
                o_cmd.avg_run = 1'b1;
                if (i_status.avg_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

endmodule

FILE: rtl/ape_datapath.sv
// Datapath of the averaged perceptron engine: stores, arithmetic, counters, result register.
`timescale 1ns / 1ps

module ape_datapath
    import ape_pkg::*;
#(
    parameter int MAX_FEATURES = 65536,
    parameter int WEIGHT_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [1:0]            i_kind,
    input  logic [15:0]           i_index,
    input  logic signed [15:0]    i_value,
    input  logic signed [1:0]     i_label,
    input  logic                  i_last,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam int AB  = $clog2(MAX_FEATURES);
    localparam int CW  = (AB + 1 > 17) ? AB + 1 : 17;
    localparam int PW  = 16 + WEIGHT_BITS;
    localparam int AW  = ((PW > SCORE_W) ? PW : SCORE_W) + 1;
    localparam int UW  = ((WEIGHT_BITS > 33) ? WEIGHT_BITS : 33) + 1;
    localparam int SW  = SUM_W + 1;

    localparam logic [CW-1:0] MAX_C = CW'(MAX_FEATURES);
    localparam logic [AB-1:0] LAST_ADDR = AB'(MAX_FEATURES - 1);

    localparam logic signed [AW-1:0] ACC_HI = {{(AW-SCORE_W+1){1'b0}}, {(SCORE_W-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_LO = {{(AW-SCORE_W+1){1'b1}}, {(SCORE_W-1){1'b0}}};
    localparam logic signed [UW-1:0] W_HI =
        {{(UW-WEIGHT_BITS+1){1'b0}}, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [UW-1:0] W_LO =
        {{(UW-WEIGHT_BITS+1){1'b1}}, {(WEIGHT_BITS-1){1'b0}}};
    localparam logic signed [SW-1:0] S_HI = {2'b00, {(SUM_W-1){1'b1}}};
    localparam logic signed [SW-1:0] S_LO = {2'b11, {(SUM_W-1){1'b0}}};

    // Configuration registers
    logic [16:0] r_num_features;
    logic [15:0] r_learn_rate;
    logic        r_lock_bias;
    logic [15:0] r_min_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_features <= 17'h10000;
            r_learn_rate   <= 16'd256;
            r_lock_bias    <= 1'b0;
            r_min_index    <= 16'd0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_NUM_FEATURES: r_num_features <= i_cfg_wdata;
                CFG_LEARN_RATE:   r_learn_rate   <= i_cfg_wdata[15:0];
                CFG_LOCK_BIAS:    r_lock_bias    <= i_cfg_wdata[0];
                CFG_MIN_INDEX:    r_min_index    <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Active feature count
    logic [CW-1:0] w_nf_ext;
    logic [CW-1:0] w_active_n;
    assign w_nf_ext   = CW'(r_num_features);
    assign w_active_n = (w_nf_ext < MAX_C) ? w_nf_ext : MAX_C;

    // Latched item
    logic [1:0]        r_kind;
    logic [15:0]       r_index;
    logic signed [15:0] r_value;
    logic [1:0]        r_sign;   // bit1 negative, bit0 positive
    logic              r_last;
    logic              r_active;
    logic              r_can_upd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind    <= (i_kind == KIND_RSVD) ? KIND_SCORE : i_kind;
            r_index   <= i_index;
            r_value   <= i_value;
            r_sign    <= {i_label[1], (i_label == 2'sd1)};
            r_last    <= i_last;
            r_active  <= (CW'(i_index) < w_active_n);
            r_can_upd <= !(r_lock_bias && (i_index == 16'd0)) && (i_index >= r_min_index);
        end
    end

    logic [AB-1:0] w_item_addr;
    assign w_item_addr = AB'(r_index);

    // Precompute the labelled step while the weight is read
    logic signed [32:0] w_lr_prod;
    logic signed [32:0] r_step;
    assign w_lr_prod = $signed({1'b0, r_learn_rate}) * r_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_item) begin
            if (r_sign[1])      r_step <= -w_lr_prod;
            else if (r_sign[0]) r_step <= w_lr_prod;
            else                r_step <= '0;
        end
    end

    // Clearing sweep counter
    logic [AB-1:0] r_clr_addr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end
    assign o_status.clear_done = i_cmd.clear && (r_clr_addr == LAST_ADDR);

    // Averaging sweep counters
    logic [CW-1:0] r_avg_cnt;
    logic          r_avg_pend;
    logic [AB-1:0] r_avg_waddr;
    logic          w_avg_issue;
    assign w_avg_issue = i_cmd.avg_run && (r_avg_cnt < w_active_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_cnt  <= '0;
            r_avg_pend <= 1'b0;
        end else if (i_cmd.avg_start) begin
            r_avg_cnt  <= '0;
            r_avg_pend <= 1'b0;
        end else if (i_cmd.avg_run) begin
            r_avg_pend <= w_avg_issue;
            if (w_avg_issue) r_avg_cnt <= r_avg_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_avg_issue) r_avg_waddr <= r_avg_cnt[AB-1:0];
    end

    assign o_status.avg_done = i_cmd.avg_run && !w_avg_issue && !r_avg_pend;

    // Weight store
    logic signed [WEIGHT_BITS-1:0] r_weight_mem [MAX_FEATURES];
    logic signed [WEIGHT_BITS-1:0] r_w_rd;
    logic [AB-1:0]                 w_w_raddr;
    logic                          w_w_we;
    logic [AB-1:0]                 w_w_waddr;
    logic signed [WEIGHT_BITS-1:0] w_w_wdata;
    logic signed [WEIGHT_BITS-1:0] w_w_new;

    assign w_w_raddr = i_cmd.avg_run ? r_avg_cnt[AB-1:0] : w_item_addr;

    // Weight update with saturation
    logic signed [UW-1:0] w_upd_sum;
    always_comb begin
        if (r_kind == KIND_LABEL) begin
            w_upd_sum = UW'(r_w_rd) + UW'(r_step);
        end else begin
            w_upd_sum = UW'(r_w_rd) + UW'($signed({r_value, 8'h00}));
        end
        if (w_upd_sum > W_HI)      w_w_new = W_HI[WEIGHT_BITS-1:0];
        else if (w_upd_sum < W_LO) w_w_new = W_LO[WEIGHT_BITS-1:0];
        else                       w_w_new = w_upd_sum[WEIGHT_BITS-1:0];
    end

    always_comb begin
        if (i_cmd.clear) begin
            w_w_we    = 1'b1;
            w_w_waddr = r_clr_addr;
            w_w_wdata = '0;
        end else begin
            w_w_we    = i_cmd.calc && r_active && r_can_upd &&
                        ((r_kind == KIND_LABEL) || (r_kind == KIND_DELTA));
            w_w_waddr = w_item_addr;
            w_w_wdata = w_w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_w_we) r_weight_mem[w_w_waddr] <= w_w_wdata;
        r_w_rd <= r_weight_mem[w_w_raddr];
    end

    // Running-sum store
    logic signed [SUM_W-1:0] r_sum_mem [MAX_FEATURES];
    logic signed [SUM_W-1:0] r_s_rd;
    logic signed [SW-1:0]    w_s_add;
    logic signed [SUM_W-1:0] w_s_new;

    always_comb begin
        w_s_add = SW'(r_s_rd) + SW'(r_w_rd);
        if (w_s_add > S_HI)      w_s_new = S_HI[SUM_W-1:0];
        else if (w_s_add < S_LO) w_s_new = S_LO[SUM_W-1:0];
        else                     w_s_new = w_s_add[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_sum_mem[r_clr_addr] <= '0;
        end else if (i_cmd.avg_run && r_avg_pend) begin
            r_sum_mem[r_avg_waddr] <= w_s_new;
        end
        r_s_rd <= r_sum_mem[r_avg_cnt[AB-1:0]];
    end

    // Score product
    logic signed [PW-1:0] r_prod;
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) r_prod <= r_value * r_w_rd;
    end

    // Score accumulator with saturation
    logic signed [SCORE_W-1:0] r_acc;
    logic signed [AW-1:0]      w_acc_sum;
    logic signed [SCORE_W-1:0] w_acc_new;

    always_comb begin
        w_acc_sum = AW'(r_acc) + AW'(r_prod);
        if (w_acc_sum > ACC_HI)      w_acc_new = ACC_HI[SCORE_W-1:0];
        else if (w_acc_sum < ACC_LO) w_acc_new = ACC_LO[SCORE_W-1:0];
        else                         w_acc_new = w_acc_sum[SCORE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.load_out) begin
            r_acc <= '0;
        end else if (i_cmd.acc && r_active && (r_kind != KIND_DELTA)) begin
            r_acc <= w_acc_new;
        end
    end

    // Tallies and result register
    logic [COUNT_W-1:0] r_correct_cnt;
    logic [COUNT_W-1:0] r_label_cnt;
    logic [COUNT_W-1:0] r_update_cnt;
    logic [COUNT_W-1:0] n_correct_cnt;
    logic [COUNT_W-1:0] n_label_cnt;
    logic [COUNT_W-1:0] n_update_cnt;
    logic               w_correct;
    logic               w_is_label;

    assign w_is_label = (r_kind == KIND_LABEL);
    assign w_correct  = w_is_label &&
        ((r_sign[0] && (r_acc > 0)) || (r_sign[1] && (r_acc < 0)));
    assign n_correct_cnt = r_correct_cnt + COUNT_W'(w_correct);
    assign n_label_cnt   = r_label_cnt + COUNT_W'(w_is_label);
    assign n_update_cnt  = r_update_cnt + COUNT_W'(r_kind != KIND_SCORE);

    logic r_out_valid;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.last      = r_last;
    assign o_status.is_update = (r_kind != KIND_SCORE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_correct_cnt <= '0;
            r_label_cnt   <= '0;
            r_update_cnt  <= '0;
            r_out_valid   <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_correct_cnt <= n_correct_cnt;
            r_label_cnt   <= n_label_cnt;
            r_update_cnt  <= n_update_cnt;
            r_out_valid   <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out_data <= {7'd0, n_update_cnt, n_label_cnt, n_correct_cnt, w_correct, r_acc};
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
